// File: rtl/sfwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwe_pkg: shared types and constants of the straight-flight wind estimator
// Holds the controller/datapath command and status structs, the angle and
// CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package sfwe_pkg;

  localparam int unsigned TURN         = 23040;
  localparam int unsigned HALF_TURN    = 11520;
  localparam int unsigned QUARTER_TURN = 5760;
  localparam int unsigned DEG_SHIFT    = 22;
  localparam int unsigned TABLE_LEN    = 24;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_START_DELAY = 3'd1;
  localparam logic [2:0] REG_MIN_AS      = 3'd2;
  localparam logic [2:0] REG_SPEED_TOL   = 3'd3;
  localparam logic [2:0] REG_HEAD_TOL    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input sample
    logic update;     // apply window logic to the captured sample
    logic div_start;  // start the averaging dividers
    logic rot_init;   // set up the rotation CORDIC
    logic vec_init;   // set up the vectoring CORDIC
    logic step;       // one CORDIC iteration
    logic finish;     // form the result registers
  } sfwe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deliver;    // the updated sample triggers a result
    logic div_done;   // both averages are ready
    logic step_last;  // the current CORDIC iteration is the last one
  } sfwe_sts_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'd188743680;
        5'd1:  r = 32'd111421900;
        5'd2:  r = 32'd58872272;
        5'd3:  r = 32'd29884485;
        5'd4:  r = 32'd15000234;
        5'd5:  r = 32'd7507429;
        5'd6:  r = 32'd3754631;
        5'd7:  r = 32'd1877430;
        5'd8:  r = 32'd938729;
        5'd9:  r = 32'd469366;
        5'd10: r = 32'd234683;
        5'd11: r = 32'd117342;
        5'd12: r = 32'd58671;
        5'd13: r = 32'd29335;
        5'd14: r = 32'd14668;
        5'd15: r = 32'd7334;
        5'd16: r = 32'd3667;
        5'd17: r = 32'd1833;
        5'd18: r = 32'd917;
        5'd19: r = 32'd458;
        5'd20: r = 32'd229;
        5'd21: r = 32'd115;
        5'd22: r = 32'd57;
        5'd23: r = 32'd29;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/sfwe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwe_div: restoring divider for the speed averages
// Computes (num * 2^16 + den / 2) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfwe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [44:0] quot_o
);

  localparam int unsigned NB = 45;

  logic [NB-1:0] dvd_q, dvd_d;
  logic [16:0]   rem_q, rem_d;
  logic [15:0]   den_q, den_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [17:0]   trial;
  logic [15:0]   den_eff;

  assign den_eff = (den_i == 16'd0) ? 16'd1 : den_i;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, dvd_q[NB-1]} - {2'b00, den_q};
    if (start_i) begin
      dvd_d  = {num_i, 16'd0} + {29'd0, den_eff >> 1};
      rem_d  = '0;
      den_d  = den_eff;
      cnt_d  = 6'(NB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        dvd_d = {dvd_q[NB-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], dvd_q[NB-1]};
        dvd_d = {dvd_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = !busy_q;
  assign quot_o = dvd_q;

endmodule

// File: rtl/sfwe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwe_datapath: window state, sums, means and the shared CORDIC unit
// Executes the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module sfwe_datapath #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned SPEED_FRAC_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfwe_pkg::sfwe_cmd_t  cmd_i,
  output sfwe_pkg::sfwe_sts_t  sts_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [13:0]          cfg_data_i,
  input  logic [31:0]          time_ms_i,
  input  logic [12:0]          airspeed_i,
  input  logic [12:0]          ground_speed_i,
  input  logic [14:0]          ground_course_i,
  input  logic [14:0]          compass_heading_i,
  input  logic signed [15:0]   altitude_i,
  output logic [13:0]          wind_speed_o,
  output logic [8:0]           wind_direction_o,
  output logic [15:0]          sample_count_o,
  output logic signed [15:0]   altitude_out_o
);

  localparam int unsigned STEPS = (CORDIC_STEPS < sfwe_pkg::TABLE_LEN) ?
                                  CORDIC_STEPS : sfwe_pkg::TABLE_LEN;
  localparam int unsigned W = 50;   // CORDIC word width
  localparam int unsigned AW = 42;  // CORDIC angle width
  localparam logic [12:0] GS_MIN_COURSE = 13'(5 << SPEED_FRAC_BITS);
  localparam logic [44:0] GS_SLOW = 45'(64'(2 << SPEED_FRAC_BITS) << 16);

  // Configuration registers.
  logic        en_q;
  logic [7:0]  delay_q;
  logic [12:0] min_as_q;
  logic [9:0]  spd_tol_q;
  logic [13:0] hd_tol_q;

  // Captured sample.
  logic [31:0] s_time_q;
  logic [12:0] s_as_q, s_gs_q;
  logic [14:0] s_tc_q, s_th_q;
  logic signed [15:0] s_alt_q;

  // Window state.
  logic [15:0] tot_q;
  logic [12:0] ref_as_q, ref_gs_q;
  logic [14:0] cwl_q, cwh_q, hwl_q, hwh_q;
  logic [28:0] as_sum_q, gs_sum_q;
  logic [14:0] mc_q, mh_q;
  logic [31:0] wst_q;
  logic [15:0] nds_q;
  logic        deliver_q;

  // CORDIC state.
  logic signed [W-1:0]  cx_q, cy_q;
  logic signed [AW-1:0] cz_q;
  logic [4:0]           it_q;
  logic                 vec_q;
  logic                 zero_q, slow_q;
  logic [44:0]          gs16_q;

  logic [44:0] tas16, gs16;
  logic        div_a_done, div_g_done;

  function automatic logic [14:0] wrap_add(input logic [14:0] a, input logic [13:0] t);
    logic [15:0] s;
    begin
      s = {1'b0, a} + {2'b00, t};
      if (s >= 16'(sfwe_pkg::TURN)) s = s - 16'(sfwe_pkg::TURN);
      return s[14:0];
    end
  endfunction

  function automatic logic [14:0] wrap_sub(input logic [14:0] a, input logic [13:0] t);
    logic [15:0] s;
    begin
      s = {1'b0, a} - {2'b00, t};
      if (s[15]) s = s + 16'(sfwe_pkg::TURN);
      return s[14:0];
    end
  endfunction

  function automatic logic [14:0] wrap_in(input logic [14:0] a);
    return (a >= 15'(sfwe_pkg::TURN)) ? 15'(a - 15'(sfwe_pkg::TURN)) : a;
  endfunction

  function automatic logic in_win(input logic [14:0] v, input logic [14:0] lo,
                                  input logic [14:0] hi);
    logic r;
    begin
      if (lo < hi)      r = !(v < lo || v > hi);
      else if (lo > hi) r = !(v < lo && v > hi);
      else              r = 1'b1;
      return r;
    end
  endfunction

  function automatic logic [14:0] bisect(input logic [14:0] a, input logic [14:0] m);
    logic [15:0] ad, b;
    logic [16:0] r;
    begin
      ad = (a >= m) ? 16'(a - m) : 16'(m - a);
      if (ad > 16'(sfwe_pkg::HALF_TURN)) begin
        b = (16'(sfwe_pkg::TURN) - ad) >> 1;
        r = (a <= m) ? 17'({1'b0, m} + b) : 17'({1'b0, m} - b);
      end else begin
        b = ad >> 1;
        r = (a <= m) ? 17'({1'b0, a} + b) : 17'({1'b0, a} - b);
      end
      if (r[16])                          r = r + 17'(sfwe_pkg::TURN);
      else if (r >= 17'(sfwe_pkg::TURN))  r = r - 17'(sfwe_pkg::TURN);
      return r[14:0];
    end
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      delay_q   <= 8'd10;
      min_as_q  <= '0;
      spd_tol_q <= 10'd160;
      hd_tol_q  <= 14'd320;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfwe_pkg::REG_ENABLE:      en_q      <= cfg_data_i[0];
        sfwe_pkg::REG_START_DELAY: delay_q   <= cfg_data_i[7:0];
        sfwe_pkg::REG_MIN_AS:      min_as_q  <= cfg_data_i[12:0];
        sfwe_pkg::REG_SPEED_TOL:   spd_tol_q <= cfg_data_i[9:0];
        sfwe_pkg::REG_HEAD_TOL:    hd_tol_q  <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_time_q <= time_ms_i;
      s_as_q   <= airspeed_i;
      s_gs_q   <= ground_speed_i;
      s_tc_q   <= wrap_in(ground_course_i);
      s_th_q   <= wrap_in(compass_heading_i);
      s_alt_q  <= altitude_i;
    end
  end

  // Window update on the captured sample.
  logic [12:0] dgs, das;
  logic        reject, fail, accept_add, due;
  logic [31:0] elapsed, due_ms;

  always_comb begin
    dgs     = (ref_gs_q >= s_gs_q) ? 13'(ref_gs_q - s_gs_q) : 13'(s_gs_q - ref_gs_q);
    das     = (ref_as_q >= s_as_q) ? 13'(ref_as_q - s_as_q) : 13'(s_as_q - ref_as_q);
    reject  = !en_q || (s_as_q < min_as_q);
    fail    = (tot_q == 16'd0) || (dgs > {3'b000, spd_tol_q}) ||
              (das > {3'b000, spd_tol_q}) || !in_win(s_th_q, hwl_q, hwh_q) ||
              ((s_gs_q >= GS_MIN_COURSE) && !in_win(s_tc_q, cwl_q, cwh_q));
    accept_add = tot_q != 16'hFFFF;
    elapsed = s_time_q - wst_q;
    due_ms  = {16'd0, nds_q} * 32'd1000;
    due     = elapsed >= due_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q     <= '0;
      ref_as_q  <= '0;
      ref_gs_q  <= '0;
      cwl_q     <= '0;
      cwh_q     <= '0;
      hwl_q     <= '0;
      hwh_q     <= '0;
      as_sum_q  <= '0;
      gs_sum_q  <= '0;
      mc_q      <= '0;
      mh_q      <= '0;
      wst_q     <= '0;
      nds_q     <= 16'd10;
      deliver_q <= 1'b0;
    end else if (cmd_i.update) begin
      deliver_q <= 1'b0;
      if (reject) begin
        tot_q <= '0;
      end else if (fail) begin
        tot_q    <= 16'd1;
        nds_q    <= {8'd0, delay_q};
        wst_q    <= s_time_q;
        ref_as_q <= s_as_q;
        ref_gs_q <= s_gs_q;
        as_sum_q <= {16'd0, s_as_q};
        gs_sum_q <= {16'd0, s_gs_q};
        mc_q     <= s_tc_q;
        mh_q     <= s_th_q;
        cwl_q    <= wrap_sub(s_tc_q, hd_tol_q);
        cwh_q    <= wrap_add(s_tc_q, hd_tol_q);
        hwl_q    <= wrap_sub(s_th_q, hd_tol_q);
        hwh_q    <= wrap_add(s_th_q, hd_tol_q);
      end else begin
        if (accept_add) begin
          tot_q    <= tot_q + 16'd1;
          as_sum_q <= as_sum_q + {16'd0, s_as_q};
          gs_sum_q <= gs_sum_q + {16'd0, s_gs_q};
          mc_q     <= bisect(s_tc_q, mc_q);
          mh_q     <= bisect(s_th_q, mh_q);
        end
        if (due) begin
          deliver_q <= 1'b1;
          if (nds_q != 16'hFFFF) nds_q <= nds_q + 16'd1;
        end
      end
    end
  end

  sfwe_div u_div_as (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (as_sum_q),
    .den_i  (tot_q),
    .done_o (div_a_done),
    .quot_o (tas16)
  );

  sfwe_div u_div_gs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (gs_sum_q),
    .den_i  (tot_q),
    .done_o (div_g_done),
    .quot_o (gs16)
  );

  // Shared CORDIC unit: rotation first, vectoring second.
  // The averaged airspeed stays below 2^30, so its low 32 bits feed the gain
  // multiplier.
  logic signed [15:0]   dang;
  logic signed [W-1:0]  gain_x, sx, sy, nx, ny, vx, vy;
  logic signed [AW-1:0] cz_init, at, nz;
  logic [61:0]          gprod;
  logic                 dir;

  always_comb begin
    dang = 16'(signed'({1'b0, mh_q}) - signed'({1'b0, mc_q}));
    if (dang > $signed(16'(sfwe_pkg::HALF_TURN))) dang = dang - 16'(sfwe_pkg::TURN);
    if (dang <= -16'sd11520)                    dang = dang + 16'(sfwe_pkg::TURN);
    gprod  = {30'd0, tas16[31:0]} * {32'd0, sfwe_pkg::INV_GAIN_Q30};
    gain_x = W'(signed'({1'b0, gprod[61:30]}));
    if (dang > $signed(16'(sfwe_pkg::QUARTER_TURN))) begin
      gain_x = -gain_x;
      dang   = dang - 16'(sfwe_pkg::HALF_TURN);
    end else if (dang < -16'sd5760) begin
      gain_x = -gain_x;
      dang   = dang + 16'(sfwe_pkg::HALF_TURN);
    end
    cz_init = AW'(dang) <<< 16;
    sx  = cx_q >>> it_q;
    sy  = cy_q >>> it_q;
    at  = AW'(signed'({1'b0, sfwe_pkg::atan_entry(it_q)}));
    dir = vec_q ? (cy_q > 0) : (cz_q >= 0);
    if (dir != vec_q) begin
      nx = cx_q - sy;
      ny = cy_q + sx;
    end else begin
      nx = cx_q + sy;
      ny = cy_q - sx;
    end
    nz = dir ? (vec_q ? cz_q + at : cz_q - at) : (vec_q ? cz_q - at : cz_q + at);
    vx = cx_q - W'(signed'({1'b0, gs16_q}));
    vy = cy_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rot_init) begin
      cx_q   <= gain_x;
      cy_q   <= '0;
      cz_q   <= cz_init;
      it_q   <= '0;
      vec_q  <= 1'b0;
      gs16_q <= gs16;
      slow_q <= gs16 < GS_SLOW;
      zero_q <= 1'b0;
    end else if (cmd_i.vec_init) begin
      zero_q <= (vx == 0) && (vy == 0);
      it_q   <= '0;
      vec_q  <= 1'b1;
      if (vx < 0) begin
        cx_q <= -vx;
        cy_q <= -vy;
        cz_q <= AW'(64'(sfwe_pkg::HALF_TURN) << 16);
      end else begin
        cx_q <= vx;
        cy_q <= vy;
        cz_q <= '0;
      end
    end else if (cmd_i.step) begin
      cx_q <= nx;
      cy_q <= ny;
      cz_q <= nz;
      it_q <= it_q + 5'd1;
    end
  end

  // Result formation. The vector magnitude stays below 2^31, so its low
  // 32 bits feed the gain multiplier.
  logic [61:0]          mprod;
  logic signed [W-1:0]  mag;
  logic signed [W-1:0]  spd16;
  logic [W-1:0]         spd_r;
  logic signed [AW+1:0] wd, full;
  logic [AW+1:0]        wdr;
  logic [9:0]           deg;
  logic [13:0]          ws;
  logic [14:0]          dir_base;

  always_comb begin
    mag   = (cx_q < 0) ? '0 : cx_q;
    mprod = {30'd0, mag[31:0]} * {32'd0, sfwe_pkg::INV_GAIN_Q30};
    if (slow_q) spd16 = W'(signed'({1'b0, tas16[44:SPEED_FRAC_BITS]}));
    else if (zero_q) spd16 = '0;
    else spd16 = W'(signed'({1'b0, mprod[61:30+SPEED_FRAC_BITS]}));
    spd_r = W'(spd16 + W'(32768)) >> 16;
    ws    = (spd_r > W'(16383)) ? 14'd16383 : spd_r[13:0];
    dir_base = slow_q ? mh_q : mc_q;
    full  = (AW+2)'(64'(sfwe_pkg::TURN) << 16);
    wd    = (AW+2)'(signed'({1'b0, dir_base})) <<< 16;
    if (!slow_q && !zero_q) wd = wd + (AW+2)'(cz_q);
    if (wd < 0)         wd = wd + full;
    else if (wd >= full) wd = wd - full;
    if (wd < 0)         wd = wd + full;
    wdr = (AW+2)'(wd + (AW+2)'(64'(1) << (sfwe_pkg::DEG_SHIFT - 1)))
          >> sfwe_pkg::DEG_SHIFT;
    deg = wdr[9:0];
    if (deg >= 10'd360) deg = 10'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      wind_speed_o     <= ws;
      wind_direction_o <= deg[8:0];
      sample_count_o   <= tot_q;
      altitude_out_o   <= s_alt_q;
    end
  end

  assign sts_o.deliver   = deliver_q;
  assign sts_o.div_done  = div_a_done && div_g_done;
  assign sts_o.step_last = it_q == 5'(STEPS - 1);

endmodule

// File: rtl/sfwe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwe_ctrl: sequencing state machine of the wind estimator
// Owns the handshakes and steps the datapath through one sample.
// ----------------------------------------------------------------------------
module sfwe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sfwe_pkg::sfwe_cmd_t cmd_o,
  input  sfwe_pkg::sfwe_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_CHECK, S_DIV, S_DIVWAIT, S_ROT, S_VINIT, S_VEC, S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   fin_go;

  // A new result may enter the output registers once the old one is gone
  // or leaves in the same cycle.
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid;
    cmd_o.update    = state_q == S_UPDATE;
    cmd_o.div_start = state_q == S_DIV;
    cmd_o.rot_init  = (state_q == S_DIVWAIT) && sts_i.div_done;
    cmd_o.vec_init  = state_q == S_VINIT;
    cmd_o.step      = (state_q == S_ROT) || (state_q == S_VEC);
    cmd_o.finish    = fin_go;
  end

  assign in_ready  = state_q == S_IDLE;
  assign out_valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:    if (cmd_o.load) state_q <= S_UPDATE;
        S_UPDATE:  state_q <= S_CHECK;
        S_CHECK:   state_q <= sts_i.deliver ? S_DIV : S_IDLE;
        S_DIV:     state_q <= S_DIVWAIT;
        S_DIVWAIT: if (sts_i.div_done) state_q <= S_ROT;
        S_ROT:     if (sts_i.step_last) state_q <= S_VINIT;
        S_VINIT:   state_q <= S_VEC;
        S_VEC:     if (sts_i.step_last) state_q <= S_FIN;
        S_FIN:     if (fin_go) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> state_q == S_IDLE) else $error("accept while busy");
  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> out_valid) else $error("result lost");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

// File: rtl/straight_flight_wind_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_flight_wind_estimator: wind from straight-flight sensor samples
// Tracks a steady-flight window and solves the wind triangle once a second.
// ----------------------------------------------------------------------------
// Sequence: a sample without a result passes the window update and check, then
// returns to idle; one that yields a result also runs the averaging dividers
// and the CORDIC rotation and vectoring, and waits for any earlier result that
// still holds the output registers. The next sample is taken once the previous
// one is finished; the dividers and the shared CORDIC unit serve one at a time.
// Reset: asynchronous, active low; sample, CORDIC and output regs are not reset.
// ----------------------------------------------------------------------------
module straight_flight_wind_estimator #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned SPEED_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        time_ms_i,
  input  logic [12:0]        airspeed_i,
  input  logic [12:0]        ground_speed_i,
  input  logic [14:0]        ground_course_i,
  input  logic [14:0]        compass_heading_i,
  input  logic signed [15:0] altitude_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [13:0]        wind_speed_o,
  output logic [8:0]         wind_direction_o,
  output logic [15:0]        sample_count_o,
  output logic signed [15:0] altitude_out_o
);

  sfwe_pkg::sfwe_cmd_t cmd;
  sfwe_pkg::sfwe_sts_t sts;

  // The controller handles both transfers; the datapath holds the data.
  sfwe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  sfwe_datapath #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .SPEED_FRAC_BITS(SPEED_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .time_ms_i        (time_ms_i),
    .airspeed_i       (airspeed_i),
    .ground_speed_i   (ground_speed_i),
    .ground_course_i  (ground_course_i),
    .compass_heading_i(compass_heading_i),
    .altitude_i       (altitude_i),
    .wind_speed_o     (wind_speed_o),
    .wind_direction_o (wind_direction_o),
    .sample_count_o   (sample_count_o),
    .altitude_out_o   (altitude_out_o)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the straight-flight wind estimator
// Drives flight samples through the valid/ready input, computes the expected
// wind results with an independent fixed-point model of the window logic and
// the wind triangle, and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
  import sfwe_pkg::*;

  // Sample payload and wind result as they appear on the ports.
  typedef struct packed {
    logic [31:0]        t;
    logic [12:0]        as;
    logic [12:0]        gs;
    logic [14:0]        tc;
    logic [14:0]        th;
    logic signed [15:0] alt;
  } sample_t;

  typedef struct packed {
    logic [13:0]        ws;
    logic [8:0]         wd;
    logic [15:0]        cnt;
    logic signed [15:0] alt;
  } wind_t;

  // A directed row either writes a register or offers one sample. Rows with
  // a typed expectation carry the wind result that is obvious from the inputs.
  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [13:0] data;
    sample_t     s;
    bit          typed;
    wind_t       w;
  } row_t;

  localparam longint FULL_TURN = 23040;
  localparam longint HALF = 11520;
  localparam longint QUARTER = 5760;
  localparam int STEPS = 16;
  localparam int SETTLE_CYCLES = 150;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [13:0]        cfg_data_i = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        time_ms_i = '0;
  logic [12:0]        airspeed_i = '0;
  logic [12:0]        ground_speed_i = '0;
  logic [14:0]        ground_course_i = '0;
  logic [14:0]        compass_heading_i = '0;
  logic signed [15:0] altitude_i = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [13:0]        wind_speed_o;
  logic [8:0]         wind_direction_o;
  logic [15:0]        sample_count_o;
  logic signed [15:0] altitude_out_o;

  straight_flight_wind_estimator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid, .in_ready, .time_ms_i, .airspeed_i, .ground_speed_i,
    .ground_course_i, .compass_heading_i, .altitude_i,
    .out_valid, .out_ready, .wind_speed_o, .wind_direction_o,
    .sample_count_o, .altitude_out_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and of the window state.
  bit          en_q;
  int unsigned delay_q, min_as_q, spd_tol_q, hdg_tol_q;
  int unsigned n_q, ref_as_q, ref_gs_q, crs_lo_q, crs_hi_q, hdg_lo_q, hdg_hi_q;
  longint      as_sum_q, gs_sum_q;
  int unsigned mean_crs_q, mean_hdg_q, win_t0_q, next_s_q;

  wind_t pending_winds[$];
  int    errors = 0;
  bit    hold_req = 1'b0;

  longint atan_q22[24] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };

  function automatic int unsigned wrap_deg64(longint a);
    longint r;
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return int'(r);
  endfunction

  // An equal pair of limits always passes; a wrapped window fails only in
  // the gap between its high and low limit.
  function automatic bit in_arc(int unsigned v, int unsigned lo, int unsigned hi);
    if (lo < hi) return !(v < lo || v > hi);
    if (lo > hi) return !(v < lo && v > hi);
    return 1'b1;
  endfunction

  // Bisector of a new angle and the running mean, the odd half truncating.
  function automatic int unsigned halfway(int unsigned a, int unsigned m);
    longint d, b;
    d = longint'(a) - longint'(m);
    if (d < 0) d = -d;
    if (d > HALF) begin
      b = (FULL_TURN - d) / 2;
      return wrap_deg64((a <= m) ? m + b : m - b);
    end
    b = d / 2;
    return wrap_deg64((a <= m) ? a + b : a - b);
  endfunction

  function automatic logic [13:0] round_speed(longint v16);
    longint s;
    s = (v16 + 32768) >>> 16;
    if (s < 0) s = 0;
    if (s > 16383) s = 16383;
    return s[13:0];
  endfunction

  function automatic logic [8:0] round_deg(longint wd);
    longint full, d;
    full = FULL_TURN * 65536;
    wd = wd % full;
    if (wd < 0) wd += full;
    d = (wd + (longint'(1) << 21)) >>> DEG_SHIFT;
    if (d >= 360) d = 0;
    return d[8:0];
  endfunction

  // Wind triangle: rotate the averaged airspeed by heading minus course,
  // subtract ground speed, then take magnitude and angle of what remains.
  function automatic void solve_triangle(output logic [13:0] ws, output logic [8:0] wd);
    longint n, tas, gsp, x, y, z, d, nx, gain;
    gain = longint'(INV_GAIN_Q30);
    n = (n_q == 0) ? 1 : n_q;
    tas = ((as_sum_q <<< 16) + n / 2) / n;
    gsp = ((gs_sum_q <<< 16) + n / 2) / n;
    if (gsp < (longint'(2) << 4) * 65536) begin
      ws = round_speed(tas >>> 4);
      wd = round_deg(longint'(mean_hdg_q) * 65536);
      return;
    end
    d = longint'(mean_hdg_q) - longint'(mean_crs_q);
    if (d > HALF) d -= FULL_TURN;
    if (d <= -HALF) d += FULL_TURN;
    x = (tas * gain) >>> 30;
    y = 0;
    if (d > QUARTER) begin
      x = -x;
      d -= HALF;
    end else if (d < -QUARTER) begin
      x = -x;
      d += HALF;
    end
    z = d * 65536;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q22[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q22[i];
      end
      x = nx;
    end
    x -= gsp;
    if (x == 0 && y == 0) begin
      ws = '0;
      wd = round_deg(longint'(mean_crs_q) * 65536);
      return;
    end
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF * 65536;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_q22[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_q22[i];
      end
      x = nx;
    end
    if (x < 0) x = 0;
    ws = round_speed(((x * gain) >>> 30) >>> 4);
    wd = round_deg(longint'(mean_crs_q) * 65536 + z);
  endfunction

  function automatic void open_window(sample_t s, int unsigned tc, int unsigned th);
    n_q = 1;
    next_s_q = delay_q;
    win_t0_q = s.t;
    ref_as_q = s.as;
    ref_gs_q = s.gs;
    as_sum_q = s.as;
    gs_sum_q = s.gs;
    mean_crs_q = tc;
    mean_hdg_q = th;
    crs_lo_q = wrap_deg64(longint'(tc) - hdg_tol_q);
    crs_hi_q = wrap_deg64(longint'(tc) + hdg_tol_q);
    hdg_lo_q = wrap_deg64(longint'(th) - hdg_tol_q);
    hdg_hi_q = wrap_deg64(longint'(th) + hdg_tol_q);
  endfunction

  // Advances the window state by one accepted sample; returns 1 with the
  // wind result when the sample falls due for a delivery.
  function automatic bit advance_window(sample_t s, output wind_t w);
    int unsigned tc, th;
    longint dgs, das;
    logic [31:0] elapsed;
    tc = wrap_deg64(s.tc);
    th = wrap_deg64(s.th);
    w = '0;
    if (!en_q || s.as < min_as_q) begin
      n_q = 0;
      return 1'b0;
    end
    if (n_q == 0) begin
      open_window(s, tc, th);
      return 1'b0;
    end
    dgs = longint'(ref_gs_q) - longint'(s.gs);
    das = longint'(ref_as_q) - longint'(s.as);
    if (dgs < 0) dgs = -dgs;
    if (das < 0) das = -das;
    if (dgs > spd_tol_q || das > spd_tol_q || !in_arc(th, hdg_lo_q, hdg_hi_q) ||
        (s.gs >= 80 && !in_arc(tc, crs_lo_q, crs_hi_q))) begin
      open_window(s, tc, th);
      return 1'b0;
    end
    // A full count keeps the sums and means frozen.
    if (n_q < 65535) begin
      n_q++;
      as_sum_q += s.as;
      gs_sum_q += s.gs;
      mean_crs_q = halfway(tc, mean_crs_q);
      mean_hdg_q = halfway(th, mean_hdg_q);
    end
    elapsed = s.t - win_t0_q;
    if (elapsed >= next_s_q * 1000) begin
      if (next_s_q < 65535) next_s_q++;
      solve_triangle(w.ws, w.wd);
      w.cnt = n_q[15:0];
      w.alt = s.alt;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Gap before an item: often none, so that back-to-back stretches occur.
  function automatic int draw_gap(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Offers one sample and waits for its transfer; a typed expectation takes
  // the place of the predicted one, the model state still being advanced.
  task automatic offer_sample(sample_t s, int gap, bit typed = 1'b0, wind_t tw = '0);
    wind_t w;
    bit    due;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    time_ms_i         <= s.t;
    airspeed_i        <= s.as;
    ground_speed_i    <= s.gs;
    ground_course_i   <= s.tc;
    compass_heading_i <= s.th;
    altitude_i        <= s.alt;
    in_valid          <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    due = advance_window(s, w);
    if (typed) pending_winds.push_back(tw);
    else if (due) pending_winds.push_back(w);
  endtask

  // Registers change only with the block idle: all results in, and enough
  // cycles for a sample without a result to finish.
  task automatic write_reg(logic [2:0] idx, logic [13:0] data);
    in_valid <= 1'b0;
    while (pending_winds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      REG_ENABLE:      en_q = data[0];
      REG_START_DELAY: delay_q = data[7:0];
      REG_MIN_AS:      min_as_q = data[12:0];
      REG_SPEED_TOL:   spd_tol_q = data[9:0];
      REG_HEAD_TOL:    hdg_tol_q = data[13:0];
      default: ;
    endcase
  endtask

  // Output checker: each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    wind_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_winds.size() == 0) begin
        report_mismatch("unexpected result, wind_speed", wind_speed_o, -1);
      end else begin
        want = pending_winds.pop_front();
        if (wind_speed_o !== want.ws) report_mismatch("wind_speed", wind_speed_o, want.ws);
        if (wind_direction_o !== want.wd)
          report_mismatch("wind_direction", wind_direction_o, want.wd);
        if (sample_count_o !== want.cnt)
          report_mismatch("sample_count", sample_count_o, want.cnt);
        if (altitude_out_o !== want.alt)
          report_mismatch("altitude_out", altitude_out_o, want.alt);
      end
    end
  end

  // Receiver: a random stall per result, and one long hold-off on request
  // while the sender keeps offering samples.
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = draw_gap(1'b0);
      if (hold_req) begin
        hold_req = 1'b0;
        n = 600;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Hard limit on the run.
  initial begin
    #60_000_000;
    $display("straight_flight_wind_estimator regression: fail");
    $finish;
  end

  row_t steps_tab[] = '{
    // Disabled after reset: every sample is dropped, extremes included.
    '{ROW_SMP, 0, 0, '{32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF, 15'h7FFF, 15'h7FFF, 16'sh7FFF},
      0, '0},
    '{ROW_SMP, 0, 0, '{32'd0, 13'd0, 13'd0, 15'd0, 15'd0, -16'sd1024}, 0, '0},
    '{ROW_CFG, REG_ENABLE, 14'd1, '0, 0, '0},
    '{ROW_CFG, REG_START_DELAY, 14'd1, '0, 0, '0},
    // Slow ground: the result is the averaged airspeed along the heading.
    '{ROW_SMP, 0, 0, '{32'd0, 13'd1600, 13'd0, 15'd0, 15'd0, -16'sd1024}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd1000, 13'd1600, 13'd0, 15'd0, 15'd0, 16'sd32767},
      1, '{14'd100, 9'd0, 16'd2, 16'sd32767}},
    // Airspeed beyond tolerance reopens; then a wrapped heading window.
    '{ROW_SMP, 0, 0, '{32'd1200, 13'd1761, 13'd0, 15'd0, 15'd0, 16'sd5}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd1300, 13'd1761, 13'd0, 15'd200, 15'd23000, 16'sd6}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd2300, 13'd1700, 13'd10, 15'd23001, 15'd22999, 16'sd7}, 0, '0},
    // Heading above a full turn is reduced and then fails the window.
    '{ROW_SMP, 0, 0, '{32'd2400, 13'd1700, 13'd10, 15'd0, 15'd32767, 16'sd8}, 0, '0},
    // Proper wind triangle, including a course given above a full turn.
    '{ROW_SMP, 0, 0, '{32'd5000, 13'd1600, 13'd1400, 15'd1000, 15'd2000, 16'sd9}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd6000, 13'd1610, 13'd1390, 15'd1100, 15'd2101, 16'sd10}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd7000, 13'd1605, 13'd1420, 15'd24040, 15'd2050, 16'sd11}, 0, '0},
    // Below 5 km/h the course is not checked.
    '{ROW_SMP, 0, 0, '{32'd9000, 13'd1600, 13'd70, 15'd15000, 15'd2000, 16'sd12}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd10000, 13'd1600, 13'd79, 15'd300, 15'd2000, 16'sd13}, 0, '0},
    // Minimum airspeed at its top value.
    '{ROW_CFG, REG_MIN_AS, 14'd8191, '0, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd11000, 13'd8190, 13'd8191, 15'd0, 15'd0, 16'sd1}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd11500, 13'd8191, 13'd8191, 15'd23039, 15'd23039, 16'sd2}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd12500, 13'd8191, 13'd8191, 15'd23039, 15'd23039, 16'sd3}, 0, '0},
    '{ROW_CFG, REG_MIN_AS, 14'd0, '0, 0, '0},
    // Zero tolerances: equal limits let every angle through.
    '{ROW_CFG, REG_SPEED_TOL, 14'd0, '0, 0, '0},
    '{ROW_CFG, REG_HEAD_TOL, 14'd0, '0, 0, '0},
    '{ROW_SMP, 0, 0, '{32'hFFFF_FE00, 13'd800, 13'd900, 15'd100, 15'd5000, 16'sd4}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'h0000_0300, 13'd800, 13'd900, 15'd20000, 15'd17000, 16'sd5}, 0, '0},
    // Half-turn tolerance, widest speed tolerance.
    '{ROW_CFG, REG_SPEED_TOL, 14'd1023, '0, 0, '0},
    '{ROW_CFG, REG_HEAD_TOL, 14'd11520, '0, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd0, 13'd3000, 13'd4000, 15'd0, 15'd11520, 16'sd6}, 0, '0},
    '{ROW_SMP, 0, 0, '{32'd1000, 13'd4023, 13'd2977, 15'd11520, 15'd0, 16'sd7}, 0, '0}
  };

  initial begin
    sample_t s, base;
    bit      quiet;
    int      len, step_max, hdg_span, delta;
    int unsigned now;
    en_q = 0; delay_q = 10; min_as_q = 0; spd_tol_q = 160; hdg_tol_q = 320;
    n_q = 0; ref_as_q = 0; ref_gs_q = 0; crs_lo_q = 0; crs_hi_q = 0;
    hdg_lo_q = 0; hdg_hi_q = 0; as_sum_q = 0; gs_sum_q = 0;
    mean_crs_q = 0; mean_hdg_q = 0; win_t0_q = 0; next_s_q = 10;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps_tab[i]) begin
      if (steps_tab[i].kind == ROW_CFG) write_reg(steps_tab[i].idx, steps_tab[i].data);
      else offer_sample(steps_tab[i].s, draw_gap(1'b0), steps_tab[i].typed, steps_tab[i].w);
    end

    // Steady samples in one window, then a later one that delivers twice.
    write_reg(REG_HEAD_TOL, 14'd320);
    s = '{32'd0, 13'd1200, 13'd1000, 15'd7000, 15'd7100, 16'sd100};
    for (int k = 0; k < 8; k++) offer_sample(s, 0);
    s.t = 32'd2000;
    s.as = 13'd1300;
    offer_sample(s, 0);
    offer_sample(s, 3);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_ENABLE, (ph == 5) ? 14'($urandom_range(0, 1)) : 14'd1);
      write_reg(REG_START_DELAY, (ph == 6) ? 14'd255 : 14'($urandom_range(1, 3)));
      write_reg(REG_MIN_AS, (ph == 4) ? 14'd8191 : 14'($urandom_range(0, 400)));
      write_reg(REG_SPEED_TOL, (ph == 1) ? 14'd0 : (ph == 2) ? 14'd1023 :
                14'($urandom_range(0, 1023)));
      write_reg(REG_HEAD_TOL, (ph == 1) ? 14'd0 : (ph == 3) ? 14'd11520 :
                14'($urandom_range(0, 11520)));
      if (ph == 2) hold_req = 1'b1;
      step_max = delay_q * 1000 / 4 + 400;
      now = $urandom();
      for (int seq = 0; seq < 6; seq++) begin
        quiet = ($urandom_range(0, 4) == 0);
        base.as  = (min_as_q == 8191) ? 13'h1FFF : 13'($urandom_range(min_as_q, 8191));
        base.gs  = 13'($urandom());
        base.tc  = 15'($urandom_range(0, 32767));
        base.th  = 15'($urandom_range(0, 32767));
        len = $urandom_range(4, 16);
        for (int k = 0; k < len; k++) begin
          s = base;
          s.alt = 16'($urandom());
          now += $urandom_range(50, step_max);
          s.t = now;
          if ($urandom_range(0, 9) == 0) begin
            s.as = 13'($urandom());
            s.gs = 13'($urandom());
            s.tc = 15'($urandom());
            s.th = 15'($urandom());
          end else if (k > 0) begin
            delta = $signed($urandom_range(0, 2 * spd_tol_q)) - int'(spd_tol_q);
            s.as = 13'(((int'(base.as) + delta) < 0) ? 0 : int'(base.as) + delta);
            delta = $signed($urandom_range(0, 2 * spd_tol_q)) - int'(spd_tol_q);
            s.gs = 13'(((int'(base.gs) + delta) < 0) ? 0 : int'(base.gs) + delta);
            hdg_span = hdg_tol_q;
            s.tc = 15'(wrap_deg64(longint'(base.tc) +
                   $signed($urandom_range(0, 2 * hdg_span)) - hdg_span));
            s.th = 15'(wrap_deg64(longint'(base.th) +
                   $signed($urandom_range(0, 2 * hdg_span)) - hdg_span));
            // Occasionally present an angle above a full turn.
            if ($urandom_range(0, 7) == 0 && s.th < 32768 - 23040) s.th += 15'd23040;
          end
          offer_sample(s, draw_gap(quiet));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_winds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("straight_flight_wind_estimator regression: pass");
    end else begin
      $display("straight_flight_wind_estimator regression: fail");
    end
    $finish;
  end

endmodule
